/* hdl/mep_pkg.sv */
// mep_pkg: shared widths, constants, the queue word type and the shade gradient
// for the mandelbrot escape pixel block; depends on nothing

package mep_pkg;

	// defaults for the top level parameters
	localparam int MAX_ITER_DEF   = 200;
	localparam int COORD_BITS_DEF = 12;

	// configuration port
	localparam int DIM_W     = 13;
	localparam int CFG_IDX_W = 1;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_IMAGE_WIDTH  = 1'b0;
	localparam cfg_idx_t REG_IMAGE_HEIGHT = 1'b1;
	localparam logic [DIM_W-1:0] DIM_RESET = 13'd800;

	// result fields
	localparam int OUT_COORD_W = 12;
	localparam int COUNT_W     = 8;
	localparam int SHADE_W     = 8;

	// fixed point arithmetic, values scaled by 1000
	localparam int SPAN       = 4000;
	localparam int ESCAPE_SQ  = 4000000;
	localparam int ESCAPE_ABS = 2000;   // |c| above this escapes at once
	localparam int Z_W        = 14;     // z stays within +-6000
	localparam int SQ_W       = 28;     // z squared
	localparam int MUL_W      = 20;     // operand width of the shared multiplier
	localparam int PROD_W     = 2 * MUL_W;
	localparam int Q_W        = 14;     // quotient by 1000 or 500, at most 4000

	// divide by 125 as multiply by reciprocal, exact for operands below 2^19
	localparam logic [MUL_W-1:0] RECIP_125 = 20'd536871;
	localparam int RECIP_SHIFT = 26;

	// shade gradient: it settles long before the end of the table
	localparam int SHADE_START = 20;
	localparam int SHADE_LAST  = 30;
	localparam int GRAD_LEN    = 64;
	localparam int GRAD_IDX_W  = 6;
	typedef logic [SHADE_W-1:0] grad_t [GRAD_LEN];

	function automatic grad_t build_grad();
		grad_t g;
		int c;
		c = SHADE_START;
		for (int i = 0; i < GRAD_LEN; i++) begin
			g[i] = SHADE_W'(c);
			c = c + (255 - c) / 8;
		end
		return g;
	endfunction

	localparam grad_t SHADE_GRAD = build_grad();

	// front to back queue
	localparam int QUEUE_DEPTH = 2;   // power of two, pointers wrap
	localparam int QPTR_W      = 1;

	typedef struct packed {
		logic [OUT_COORD_W-1:0] x;
		logic [OUT_COORD_W-1:0] y;
		logic signed [Z_W-1:0]  cx;
		logic signed [Z_W-1:0]  cy;
		logic                   escaped;   // |cx| or |cy| beyond the escape radius
	} job_t;

endpackage

/* hdl/mep_ifs.sv */
// mep_in_if and mep_out_if: valid/ready channels for pixel words and result words
// depends on mep_pkg

interface mep_in_if import mep_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) ();
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;

	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface mep_out_if import mep_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [OUT_COORD_W-1:0] out_x;
	logic [OUT_COORD_W-1:0] out_y;
	logic [COUNT_W-1:0]     iteration_count;
	logic [SHADE_W-1:0]     shade;

	modport source (output valid, output out_x, output out_y, output iteration_count,
		output shade, input ready);
	modport sink (input valid, input out_x, input out_y, input iteration_count,
		input shade, output ready);
endinterface

/* hdl/mep_front.sv */
// mep_front: accepts pixel words and maps them to the complex point c with one
// radix-2 restoring divider shared by both axes; depends on mep_pkg, mep_ifs

module mep_front import mep_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [DIM_W-1:0] image_width,
	input  logic [DIM_W-1:0] image_height,
	mep_in_if.sink           pix_in,
	output logic             job_valid,
	input  logic             job_ready,
	output job_t             job
);

	localparam int AXIS_W = (COORD_BITS > 12) ? COORD_BITS : 12;
	localparam int DIFF_W = AXIS_W + 1;
	localparam int MAG_W  = AXIS_W + 12;
	localparam int CNT_W  = $clog2(MAG_W);
	localparam int REM_W  = DIM_W + 1;

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_DIVX = 4'b0010,
		F_DIVY = 4'b0100,
		F_PUSH = 4'b1000
	} fstate_t;

	fstate_t state_q;

	logic [COORD_BITS-1:0] px_q, py_q;
	logic [DIM_W-1:0]      div_q;
	logic [DIM_W-1:0]      rem_q;
	logic [MAG_W-1:0]      quo_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  neg_q;
	logic signed [Z_W-1:0] cx_q, cy_q;
	logic                  xbig_q, ybig_q;

	// operand select: x at accept, y once x is done
	logic [COORD_BITS-1:0]    pos_sel;
	logic [DIM_W-1:0]         dim_raw, dim_sel;
	logic signed [DIFF_W-1:0] diff;
	logic                     diff_neg;
	logic [AXIS_W-1:0]        diff_abs;
	logic [MAG_W-1:0]         load_mag;

	always_comb begin
		pos_sel  = (state_q == F_IDLE) ? pix_in.pixel_x : py_q;
		dim_raw  = (state_q == F_IDLE) ? image_width : image_height;
		dim_sel  = (dim_raw == '0) ? DIM_W'(1) : dim_raw;
		diff     = $signed({1'b0, AXIS_W'(pos_sel)})
			- $signed({1'b0, AXIS_W'(dim_sel[DIM_W-1:1])});
		diff_neg = diff[DIFF_W-1];
		diff_abs = AXIS_W'(diff_neg ? -diff : diff);
		load_mag = MAG_W'(diff_abs) * MAG_W'(SPAN);
	end

	// one quotient bit a cycle
	logic [REM_W-1:0]      rem_sh;
	logic [REM_W:0]        trial;
	logic                  fits;
	logic [DIM_W-1:0]      rem_nx;
	logic [MAG_W-1:0]      quo_nx;
	logic                  res_big;
	logic [Z_W-1:0]        res_mag;
	logic signed [Z_W-1:0] res_val;

	always_comb begin
		rem_sh  = {rem_q, quo_q[MAG_W-1]};
		trial   = {1'b0, rem_sh} - {2'b00, div_q};
		fits    = !trial[REM_W];
		rem_nx  = fits ? trial[DIM_W-1:0] : rem_sh[DIM_W-1:0];
		quo_nx  = {quo_q[MAG_W-2:0], fits};
		res_big = quo_nx > MAG_W'(ESCAPE_ABS);
		res_mag = {3'b000, quo_nx[10:0]};
		res_val = neg_q ? -$signed(res_mag) : $signed(res_mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: if (pix_in.valid) state_q <= F_DIVX;
				F_DIVX: if (cnt_q == '0) state_q <= F_DIVY;
				F_DIVY: if (cnt_q == '0) state_q <= F_PUSH;
				F_PUSH: if (job_ready) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				if (pix_in.valid) begin
					px_q  <= pix_in.pixel_x;
					py_q  <= pix_in.pixel_y;
					rem_q <= '0;
					quo_q <= load_mag;
					div_q <= dim_sel;
					neg_q <= diff_neg;
					cnt_q <= CNT_W'(MAG_W - 1);
				end
			end
			F_DIVX: begin
				if (cnt_q == '0) begin
					cx_q   <= res_val;
					xbig_q <= res_big;
					// start the y axis
					rem_q  <= '0;
					quo_q  <= load_mag;
					div_q  <= dim_sel;
					neg_q  <= diff_neg;
					cnt_q  <= CNT_W'(MAG_W - 1);
				end else begin
					rem_q <= rem_nx;
					quo_q <= quo_nx;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			F_DIVY: begin
				if (cnt_q == '0) begin
					cy_q   <= res_val;
					ybig_q <= res_big;
				end else begin
					rem_q <= rem_nx;
					quo_q <= quo_nx;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			F_PUSH: ;
			default: ;
		endcase
	end

	assign pix_in.ready = (state_q == F_IDLE);
	assign job_valid    = (state_q == F_PUSH);

	always_comb begin
		job.x       = OUT_COORD_W'(px_q);
		job.y       = OUT_COORD_W'(py_q);
		job.cx      = cx_q;
		job.cy      = cy_q;
		job.escaped = xbig_q | ybig_q;
	end

endmodule

/* hdl/mep_queue.sv */
// mep_queue: two-word queue of mapped pixels between front and back
// depends on mep_pkg

module mep_queue import mep_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output job_t pop_data
);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push, do_pop;

	assign push_ready = (count_q != (QPTR_W + 1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

/* hdl/mep_back.sv */
// mep_back: escape iteration on one shared registered multiplier, shade lookup and
// the output register; depends on mep_pkg, mep_ifs

module mep_back import mep_pkg::*; #(
	parameter int MAX_ITER = MAX_ITER_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      job_valid,
	output logic      job_ready,
	input  job_t      job,
	mep_out_if.source pix_out
);

	localparam int N_W = $clog2(MAX_ITER + 1);

	typedef enum logic [8:0] {
		B_IDLE = 9'b000000001,
		B_MXX  = 9'b000000010,
		B_MYY  = 9'b000000100,
		B_MXY  = 9'b000001000,
		B_CHK  = 9'b000010000,
		B_DYY  = 9'b000100000,
		B_DXY  = 9'b001000000,
		B_UPD  = 9'b010000000,
		B_DONE = 9'b100000000
	} bstate_t;

	bstate_t state_q;
	logic    out_valid_q;

	logic signed [Z_W-1:0]  zx_q, zy_q, cx_q, cy_q;
	logic [OUT_COORD_W-1:0] x_q, y_q;
	logic [N_W-1:0]         n_q;
	logic [SQ_W-1:0]        sxx_q, syy_q, sxy_q;
	logic [Q_W-1:0]         qxx_q, qyy_q;
	logic                   xy_neg_q;
	logic [PROD_W-1:0]      prod_q;

	logic [OUT_COORD_W-1:0] out_x_q, out_y_q;
	logic [COUNT_W-1:0]     out_cnt_q;
	logic [SHADE_W-1:0]     out_shade_q;

	logic [Z_W-1:0]   zx_abs, zy_abs;
	logic [MUL_W-1:0] mul_a, mul_b;
	logic [Q_W-1:0]   quo;
	logic [SQ_W:0]    mag_sq;
	logic             escape;
	logic             out_load;
	logic [SHADE_W-1:0] shade_nx;
	logic signed [Z_W+1:0] nx, ny, qxy_s;

	always_comb begin
		zx_abs = Z_W'(zx_q[Z_W-1] ? -zx_q : zx_q);
		zy_abs = Z_W'(zy_q[Z_W-1] ? -zy_q : zy_q);
		quo    = prod_q[RECIP_SHIFT +: Q_W];
		mag_sq = {1'b0, sxx_q} + {1'b0, syy_q};
		escape = mag_sq > (SQ_W + 1)'(ESCAPE_SQ);
		qxy_s  = $signed({2'b00, quo});
		nx     = $signed({2'b00, qxx_q}) - $signed({2'b00, qyy_q})
			+ $signed({{2{cx_q[Z_W-1]}}, cx_q});
		ny     = (xy_neg_q ? -qxy_s : qxy_s) + $signed({{2{cy_q[Z_W-1]}}, cy_q});
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			B_MXX: begin
				mul_a = MUL_W'(zx_abs);
				mul_b = MUL_W'(zx_abs);
			end
			B_MYY: begin
				mul_a = MUL_W'(zy_abs);
				mul_b = MUL_W'(zy_abs);
			end
			B_MXY: begin
				mul_a = MUL_W'(zx_abs);
				mul_b = MUL_W'(zy_abs);
			end
			// divide by 1000 as (v / 8) / 125
			B_CHK: begin
				mul_a = MUL_W'(sxx_q >> 3);
				mul_b = RECIP_125;
			end
			B_DYY: begin
				mul_a = MUL_W'(syy_q >> 3);
				mul_b = RECIP_125;
			end
			// divide by 500 as (v / 4) / 125
			B_DXY: begin
				mul_a = MUL_W'(sxy_q >> 2);
				mul_b = RECIP_125;
			end
			default: ;
		endcase
	end

	always_comb begin
		if (n_q == N_W'(MAX_ITER)) shade_nx = SHADE_W'(SHADE_LAST);
		else if (int'(n_q) >= GRAD_LEN) shade_nx = SHADE_GRAD[GRAD_LEN-1];
		else shade_nx = SHADE_GRAD[GRAD_IDX_W'(n_q)];
	end

	assign out_load  = (state_q == B_DONE) && (!out_valid_q || pix_out.ready);
	assign job_ready = (state_q == B_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (pix_out.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: if (job_valid) state_q <= job.escaped ? B_DONE : B_MXX;
				B_MXX:  state_q <= B_MYY;
				B_MYY:  state_q <= B_MXY;
				B_MXY:  state_q <= B_CHK;
				B_CHK:  state_q <= escape ? B_DONE : B_DYY;
				B_DYY:  state_q <= B_DXY;
				B_DXY:  state_q <= B_UPD;
				B_UPD:  state_q <= (n_q == N_W'(MAX_ITER - 1)) ? B_DONE : B_MXX;
				B_DONE: if (out_load) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		unique case (state_q)
			B_IDLE: begin
				if (job_valid) begin
					x_q  <= job.x;
					y_q  <= job.y;
					cx_q <= job.cx;
					cy_q <= job.cy;
					zx_q <= job.cx;
					zy_q <= job.cy;
					n_q  <= '0;
				end
			end
			B_MYY: sxx_q <= prod_q[SQ_W-1:0];
			B_MXY: begin
				syy_q    <= prod_q[SQ_W-1:0];
				xy_neg_q <= zx_q[Z_W-1] ^ zy_q[Z_W-1];
			end
			B_CHK: sxy_q <= prod_q[SQ_W-1:0];
			B_DYY: qxx_q <= quo;
			B_DXY: qyy_q <= quo;
			B_UPD: begin
				zx_q <= nx[Z_W-1:0];
				zy_q <= ny[Z_W-1:0];
				n_q  <= n_q + 1'b1;
			end
			default: ;
		endcase
		if (out_load) begin
			out_x_q     <= x_q;
			out_y_q     <= y_q;
			out_cnt_q   <= COUNT_W'(n_q);
			out_shade_q <= shade_nx;
		end
	end

	assign pix_out.valid           = out_valid_q;
	assign pix_out.out_x           = out_x_q;
	assign pix_out.out_y           = out_y_q;
	assign pix_out.iteration_count = out_cnt_q;
	assign pix_out.shade           = out_shade_q;

endmodule

/* hdl/mandelbrot_escape_pixel.sv */
// mandelbrot_escape_pixel: top level, image size registers, front, queue and back
// depends on mep_pkg, mep_ifs, mep_front, mep_queue, mep_back
//
// Each pixel word (pixel_x, pixel_y) is mapped to c = ((p - dim/2) * 4000) / dim per
// axis, truncated toward zero (a size register of zero acts as one), and iterated as
// z <- z*z + c in fixed point scaled by 1000, starting from z = c, until
// |z|^2 > 4000000 or MAX_ITER updates are done. The result word echoes the low 12 bits
// of the coordinate with the update count and a shade from the gradient table (count
// MAX_ITER, never escaped, gives shade 30). The front maps a pixel with its single
// one-bit-a-cycle divider, used for x then y. The back runs each iteration on one
// shared 20x20 registered multiplier (three squares/products, then three reciprocal
// multiplies for the divisions by 1000 and 500) and then updates z, plus the load
// and the output register; a pixel with c far outside goes straight from the load
// to the output register. A two-word queue lets the front map the next pixels while
// the back iterates, and the output register lets the back start the next pixel
// while a result word waits. There is no clearing pass after reset. The user must
// write image_width and image_height through wr_en / wr_index / wr_data only while
// no pixel is in flight; the block itself does not enforce this.

module mandelbrot_escape_pixel import mep_pkg::*; #(
	parameter int MAX_ITER   = MAX_ITER_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  cfg_idx_t         wr_index,
	input  logic [DIM_W-1:0] wr_data,
	mep_in_if.sink           pix_in,
	mep_out_if.source        pix_out
);

	// image size registers, reset to 800 x 800
	logic [DIM_W-1:0] width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_IMAGE_WIDTH:  width_q <= wr_data;
				REG_IMAGE_HEIGHT: height_q <= wr_data;
				default: ;
			endcase
		end
	end

	// front to queue
	logic f_valid, f_ready;
	job_t f_job;

	// queue to back
	logic b_valid, b_ready;
	job_t b_job;

	mep_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.image_width  (width_q),
		.image_height (height_q),
		.pix_in       (pix_in),
		.job_valid    (f_valid),
		.job_ready    (f_ready),
		.job          (f_job)
	);

	mep_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_job),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_job)
	);

	// iteration, shade lookup and output register
	mep_back #(
		.MAX_ITER (MAX_ITER)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (b_valid),
		.job_ready (b_ready),
		.job       (b_job),
		.pix_out   (pix_out)
	);

endmodule

/* hdl/mep_checker.sv */
// mep_checker: assertions on the result channel of mandelbrot_escape_pixel, bound
// to the top level; depends on mep_pkg and mandelbrot_escape_pixel

module mep_checker import mep_pkg::*; #(
	parameter int MAX_ITER = MAX_ITER_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [COUNT_W-1:0] iteration_count,
	input logic [SHADE_W-1:0] shade
);

	localparam bit COUNT_FITS = (MAX_ITER < 256);

	// count never passes the iteration limit
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!COUNT_FITS || iteration_count <= COUNT_W'(MAX_ITER)))
		else $error("iteration count beyond limit");

	// a point that never escaped gets the last shade
	a_shade_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && COUNT_FITS && iteration_count == COUNT_W'(MAX_ITER)
		|-> shade == SHADE_W'(SHADE_LAST))
		else $error("wrong shade for unescaped point");

	// immediate escape gets the first gradient shade
	a_shade_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && COUNT_FITS && iteration_count == '0
		|-> shade == SHADE_W'(SHADE_START))
		else $error("wrong shade for immediate escape");

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready
		|=> out_valid && $stable(iteration_count) && $stable(shade))
		else $error("result word changed under stall");

endmodule

bind mandelbrot_escape_pixel mep_checker #(
	.MAX_ITER (MAX_ITER)
) u_mep_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (pix_out.valid),
	.out_ready       (pix_out.ready),
	.iteration_count (pix_out.iteration_count),
	.shade           (pix_out.shade)
);
